FILE: rtl/utf8vc_pkg.sv
// Package for the UTF-8 validator and code point counter.
// Holds widths, byte-class constants, the result type and the scalar check.
// No dependencies.
package utf8vc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int OUT_BITS   = 16;
	localparam int CP_BITS    = 21;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};

	// Lead byte classes: mask and match pattern
	localparam logic [7:0] MASK_2 = 8'hE0;
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] MASK_3 = 8'hF0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] MASK_4 = 8'hF8;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] MASK_C = 8'hC0;
	localparam logic [7:0] CONT   = 8'h80;

	// Sequence widths in bytes
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_W2   = 3'd2;
	localparam logic [2:0] SEQ_W3   = 3'd3;
	localparam logic [2:0] SEQ_W4   = 3'd4;

	localparam logic [CP_BITS-1:0] CP_MIN_W2    = 21'h00080;
	localparam logic [CP_BITS-1:0] CP_MIN_W3    = 21'h00800;
	localparam logic [CP_BITS-1:0] CP_MIN_W4    = 21'h10000;
	localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10FFFF;
	localparam logic [CP_BITS-1:0] SURR_LO      = 21'h0D800;
	localparam logic [CP_BITS-1:0] SURR_HI      = 21'h0DFFF;
	localparam logic [CP_BITS-1:0] BIDI_EMB_LO  = 21'h0202A;
	localparam logic [CP_BITS-1:0] BIDI_EMB_HI  = 21'h0202E;
	localparam logic [CP_BITS-1:0] BIDI_ISO_LO  = 21'h02066;
	localparam logic [CP_BITS-1:0] BIDI_ISO_HI  = 21'h02069;

	typedef struct packed {
		logic                ok;
		logic [OUT_BITS-1:0] count;
	} result_t;

	// A completed scalar is refused if overlong, out of range, a surrogate
	// or a bidirectional control character.
	function automatic logic cp_acceptable(input logic [CP_BITS-1:0] cp,
		input logic [2:0] width);
		logic bad;
		bad = ((width == SEQ_W2) && (cp < CP_MIN_W2))
			|| ((width == SEQ_W3) && (cp < CP_MIN_W3))
			|| ((width == SEQ_W4) && (cp < CP_MIN_W4))
			|| (cp > CP_MAX)
			|| ((cp >= SURR_LO) && (cp <= SURR_HI))
			|| ((cp >= BIDI_EMB_LO) && (cp <= BIDI_EMB_HI))
			|| ((cp >= BIDI_ISO_LO) && (cp <= BIDI_ISO_HI));
		return !bad;
	endfunction

endpackage

FILE: rtl/utf8vc_decode.sv
// Decoder state and next-state logic: one byte per step, result on the final byte.
// Depends on utf8vc_pkg.
module utf8vc_decode (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               text_byte,
	input  logic                     end_of_string,
	output utf8vc_pkg::result_t      result
);

	logic                               error_q, error_d;
	logic [1:0]                         expect_q, expect_d;
	logic [2:0]                         width_q, width_d;
	logic [utf8vc_pkg::CP_BITS-1:0]     cp_q, cp_d;
	logic [utf8vc_pkg::COUNT_BITS-1:0]  count_q, count_d;
	logic [utf8vc_pkg::CP_BITS-1:0]     cp_next;
	logic                               accept;
	logic [32:0]                        count_ext;

	assign cp_next = {cp_q[utf8vc_pkg::CP_BITS-7:0], text_byte[5:0]};

	always_comb begin
		error_d  = error_q;
		expect_d = expect_q;
		width_d  = width_q;
		cp_d     = cp_q;
		accept   = 1'b0;
		if (!error_q) begin
			if (expect_q == 2'd0) begin
				if (!text_byte[7]) begin
					accept = 1'b1;
				end else if ((text_byte & utf8vc_pkg::MASK_2) == utf8vc_pkg::LEAD_2) begin
					cp_d     = utf8vc_pkg::CP_BITS'(text_byte[4:0]);
					width_d  = utf8vc_pkg::SEQ_W2;
					expect_d = 2'd1;
				end else if ((text_byte & utf8vc_pkg::MASK_3) == utf8vc_pkg::LEAD_3) begin
					cp_d     = utf8vc_pkg::CP_BITS'(text_byte[3:0]);
					width_d  = utf8vc_pkg::SEQ_W3;
					expect_d = 2'd2;
				end else if ((text_byte & utf8vc_pkg::MASK_4) == utf8vc_pkg::LEAD_4) begin
					cp_d     = utf8vc_pkg::CP_BITS'(text_byte[2:0]);
					width_d  = utf8vc_pkg::SEQ_W4;
					expect_d = 2'd3;
				end else begin
					error_d = 1'b1;
				end
			end else if ((text_byte & utf8vc_pkg::MASK_C) != utf8vc_pkg::CONT) begin
				error_d = 1'b1;
			end else begin
				cp_d     = cp_next;
				expect_d = expect_q - 2'd1;
				if (expect_q == 2'd1) begin
					if (utf8vc_pkg::cp_acceptable(cp_next, width_q)) begin
						accept = 1'b1;
					end else begin
						error_d = 1'b1;
					end
					cp_d    = '0;
					width_d = utf8vc_pkg::SEQ_NONE;
				end
			end
		end
		count_d = count_q;
		if (accept && (count_q != utf8vc_pkg::COUNT_MAX)) begin
			count_d = count_q + 1'b1;
		end
	end

	// The result reflects this byte; a sequence still open at the end fails.
	assign count_ext = 33'(count_d);

	always_comb begin
		result.ok    = !error_d && (expect_d == 2'd0);
		result.count = (count_ext > 33'(utf8vc_pkg::OUT_MAX)) ? utf8vc_pkg::OUT_MAX
			: count_ext[utf8vc_pkg::OUT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q  <= 1'b0;
			expect_q <= 2'd0;
			width_q  <= utf8vc_pkg::SEQ_NONE;
			cp_q     <= '0;
			count_q  <= '0;
		end else if (step) begin
			if (end_of_string) begin
				error_q  <= 1'b0;
				expect_q <= 2'd0;
				width_q  <= utf8vc_pkg::SEQ_NONE;
				cp_q     <= '0;
				count_q  <= '0;
			end else begin
				error_q  <= error_d;
				expect_q <= expect_d;
				width_q  <= width_d;
				cp_q     <= cp_d;
				count_q  <= count_d;
			end
		end
	end

endmodule

FILE: rtl/utf8_validate_count.sv
// Top level of the UTF-8 validator: input register, decoder, result register.
// Depends on utf8vc_pkg and utf8vc_decode.
//
// Streams a string in one byte per beat, with end_of_string set on the final
// byte, and returns one result per string: string_valid is 1 when the string is
// well-formed UTF-8 with no overlong form, surrogate, value above U+10FFFF or
// bidirectional control character, and codepoint_count holds the code points
// accepted before the end or the first error, saturating at 65535. A byte is
// taken every cycle unless the input stalls; each byte waits in the input
// register, and a final byte's result is registered into the output register
// as that byte leaves the input register. The only stall comes from a result
// that has not been taken while another final byte is waiting behind it.
module utf8_validate_count (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_valid,
	output logic                             byte_ready,
	input  logic [7:0]                       text_byte,
	input  logic                             end_of_string,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             string_valid,
	output logic [utf8vc_pkg::OUT_BITS-1:0]  codepoint_count
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eos_s1;
	logic                advance;
	logic                out_free;
	utf8vc_pkg::result_t result_d;
	utf8vc_pkg::result_t result_q;
	logic                out_valid_q;

	// Non-final bytes produce nothing, so only a final byte waits on the output.
	assign out_free   = !out_valid_q || result_ready;
	assign advance    = valid_s1 && (!eos_s1 || out_free);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= text_byte;
			eos_s1  <= end_of_string;
		end
	end

	utf8vc_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.text_byte     (byte_s1),
		.end_of_string (eos_s1),
		.result        (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eos_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eos_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid    = out_valid_q;
	assign string_valid    = result_q.ok;
	assign codepoint_count = result_q.count;

endmodule
